/* rtl/bvrs_pkg.sv */
// shared constants, word types and microcode program of the bit vector rank/select block
package bvrs_pkg;

   localparam int MAX_BITS      = 4096;
   localparam int BITS_PER_BYTE = 8;
   localparam int STORE_BYTES   = MAX_BITS / BITS_PER_BYTE;
   localparam int ADDR_W        = $clog2(STORE_BYTES);
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int CNT_W         = BIT_IDX_W + 1;
   localparam int LEN_W         = 13;
   localparam int ANS_W         = 14;
   localparam int STEP_W        = 3;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_RANK   = 2'd2,
      ACT_SELECT = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [7:0]       data_byte;
      logic             bit_value;
      logic [LEN_W-1:0] range_start;
      logic [LEN_W-1:0] range_end;
      logic [LEN_W-1:0] kth;
   } req_word_type;

   typedef struct packed {
      logic signed [ANS_W-1:0] answer;
      logic                    found;
   } rsp_word_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH  = step_type'(0);
   localparam step_type STEP_CLEAR  = step_type'(1);
   localparam step_type STEP_APPEND = step_type'(2);
   localparam step_type STEP_SETUP  = step_type'(3);
   localparam step_type STEP_SCAN   = step_type'(4);
   localparam step_type STEP_FINISH = step_type'(5);
   localparam step_type STEP_RESULT = step_type'(6);

   // datapath micro-operations
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_LATCH  = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_APPEND = 3'd3,
      OP_SETUP  = 3'd4,
      OP_SCAN   = 3'd5,
      OP_FINISH = 3'd6,
      OP_RESULT = 3'd7
   } uop_type;

   // next-step selection
   typedef enum logic [2:0] {
      JC_NEXT   = 3'd0,
      JC_GOTO   = 3'd1,
      JC_ACCEPT = 3'd2,
      JC_EMPTY  = 3'd3,
      JC_SCAN   = 3'd4,
      JC_OUT    = 3'd5
   } jump_type;

   typedef struct packed {
      uop_type  op;
      jump_type jump;
      step_type target;
      logic     req_ready;
   } ucode_type;

   typedef struct packed {
      uop_type op;
      logic    req_fire;
   } dp_ctrl_type;

   typedef struct packed {
      logic empty;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      case (step)
         STEP_FETCH:  uc = '{OP_LATCH,  JC_ACCEPT, STEP_FETCH,  1'b1};
         STEP_CLEAR:  uc = '{OP_CLEAR,  JC_GOTO,   STEP_RESULT, 1'b0};
         STEP_APPEND: uc = '{OP_APPEND, JC_GOTO,   STEP_RESULT, 1'b0};
         STEP_SETUP:  uc = '{OP_SETUP,  JC_EMPTY,  STEP_FINISH, 1'b0};
         STEP_SCAN:   uc = '{OP_SCAN,   JC_SCAN,   STEP_FINISH, 1'b0};
         STEP_FINISH: uc = '{OP_FINISH, JC_NEXT,   STEP_RESULT, 1'b0};
         STEP_RESULT: uc = '{OP_RESULT, JC_OUT,    STEP_FETCH,  1'b0};
         default:     uc = '{OP_NOP,    JC_GOTO,   STEP_FETCH,  1'b0};
      endcase
      return uc;
   endfunction

   function automatic step_type dispatch(input logic [1:0] action);
      step_type s;
      case (action)
         ACT_CLEAR:  s = STEP_CLEAR;
         ACT_APPEND: s = STEP_APPEND;
         ACT_RANK:   s = STEP_SETUP;
         ACT_SELECT: s = STEP_SETUP;
         default:    s = STEP_FETCH;
      endcase
      return s;
   endfunction

endpackage

/* rtl/bitvector_rank_select.sv */
// top level of the bit vector rank/select block
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_ready  req_word_type (action, byte, range, kth)
//   rsp_      out        rsp_valid / rsp_ready  rsp_word_type (answer, found)
//
// one word in flight at a time; after accept, clear and append run their own step and then the result step
// rank and select run setup, a scan over each stored byte touched by the range, finish and result;
// the scan reads one byte per cycle from the single-read-port byte store
// and pops it through one 8-bit counter
// select stops scanning at the byte that holds the wanted bit; an empty range skips the scan
// the result sits in an output register, so the next word is taken while it waits
// reset zeroes the length and returns the sequencer to its fetch step; the store is not cleared
module bitvector_rank_select (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bvrs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bvrs_pkg::rsp_word_type rsp_data
);
   import bvrs_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   // microcode sequencer: step counter plus control rom
   bvrs_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .status     (status),
      .req_ready  (req_ready),
      .ctrl       (ctrl)
   );

   // datapath: byte store, length, scan counters, output register
   bvrs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule

/* rtl/bvrs_ram.sv */
// generic single-port-write, registered-read ram
module bvrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bvrs_sequencer.sv */
// microcode step counter, control rom lookup and conditional jumps
module bvrs_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   input  bvrs_pkg::dp_status_type status,
   output logic                   req_ready,
   output bvrs_pkg::dp_ctrl_type   ctrl
);
   import bvrs_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   ucode_type uc;
   logic      fire;

   assign uc        = ucode_rom(step_ff);
   assign req_ready = uc.req_ready;
   assign fire      = req_valid & uc.req_ready;
   assign ctrl      = '{op: uc.op, req_fire: fire};

   always_comb begin
      case (uc.jump)
         JC_NEXT:   step_in = step_ff + step_type'(1);
         JC_GOTO:   step_in = uc.target;
         JC_ACCEPT: step_in = fire ? dispatch(req_action) : step_ff;
         JC_EMPTY:  step_in = status.empty ? uc.target : step_ff + step_type'(1);
         JC_SCAN:   step_in = status.scan_last ? uc.target : step_ff;
         JC_OUT:    step_in = status.out_free ? uc.target : step_ff;
         default:   step_in = STEP_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   a_ready_only_fetch: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> step_ff == STEP_FETCH)
      else $error("ready outside fetch step");

   a_fire_leaves_fetch: assert property (@(posedge clock) disable iff (reset)
      fire |=> step_ff != STEP_FETCH)
      else $error("accepted word did not start a routine");

   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_SCAN && !status.scan_last) |=> step_ff == STEP_SCAN)
      else $error("scan left early");

endmodule

/* rtl/bvrs_datapath.sv */
// byte store, length, scan counters and result registers driven by the microcode
module bvrs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bvrs_pkg::dp_ctrl_type   ctrl,
   output bvrs_pkg::dp_status_type status,
   input  bvrs_pkg::req_word_type  req_data,
   output bvrs_pkg::rsp_word_type  rsp_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready
);
   import bvrs_pkg::*;

   req_word_type     q_ff, q_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] endc_ff, endc_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             hit_ff, hit_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   rsp_word_type     res_ff, res_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0] endc, endc_m1, base;
   logic             empty, room, out_free, scan_hit;
   logic [7:0]       rd_byte, mask, match;
   logic [CNT_W-1:0] pc;
   logic             sel_hit;
   logic [BIT_IDX_W-1:0] sel_idx;
   logic             wr_en;

   bvrs_ram #(.WIDTH(BITS_PER_BYTE), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[ADDR_W+BIT_IDX_W-1:BIT_IDX_W]),
      .wr_data (q_ff.data_byte),
      .rd_addr (addr_in),
      .rd_data (rd_byte)
   );

   // query range after clamping
   assign endc    = (q_ff.range_end > len_ff) ? len_ff : q_ff.range_end;
   assign endc_m1 = endc - LEN_W'(1);
   assign empty   = (q_ff.range_start >= endc) ||
                    (q_ff.action == ACT_SELECT && q_ff.kth == '0);
   assign room    = ({1'b0, len_ff} + (LEN_W+1)'(BITS_PER_BYTE)) <= (LEN_W+1)'(MAX_BITS);
   assign base    = LEN_W'({addr_ff, {BIT_IDX_W{1'b0}}});
   assign match   = q_ff.bit_value ? rd_byte : ~rd_byte;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [LEN_W-1:0] p;
      logic [CNT_W-1:0] pre;
      mask    = '0;
      pc      = '0;
      pre     = '0;
      sel_hit = 1'b0;
      sel_idx = '0;
      for (int j = 0; j < BITS_PER_BYTE; j++) begin
         p       = base + LEN_W'(j);
         mask[j] = (p >= q_ff.range_start) && (p < endc_ff);
      end
      for (int j = 0; j < BITS_PER_BYTE; j++) begin
         pc  = pc + CNT_W'(match[j] & mask[j]);
         pre = pre + CNT_W'(match[j] & mask[j]);
         if (!sel_hit && match[j] && mask[j] && LEN_W'(pre) == rem_ff) begin
            sel_hit = 1'b1;
            sel_idx = BIT_IDX_W'(j);
         end
      end
   end

   assign scan_hit = (q_ff.action == ACT_SELECT) && sel_hit;

   assign status = '{empty: empty,
                     scan_last: scan_hit || (addr_ff == last_ff),
                     out_free: out_free};

   always_comb begin
      q_in         = q_ff;
      len_in       = len_ff;
      endc_in      = endc_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      wr_en        = 1'b0;
      case (ctrl.op)
         OP_LATCH: begin
            if (ctrl.req_fire) begin
               q_in = req_data;
            end
         end
         OP_CLEAR: begin
            len_in = '0;
            res_in = '{answer: '0, found: 1'b1};
         end
         OP_APPEND: begin
            if (room) begin
               wr_en  = 1'b1;
               len_in = len_ff + LEN_W'(BITS_PER_BYTE);
               res_in = '{answer: '0, found: 1'b1};
            end else begin
               res_in = '{answer: '0, found: 1'b0};
            end
         end
         OP_SETUP: begin
            endc_in  = endc;
            last_in  = endc_m1[ADDR_W+BIT_IDX_W-1:BIT_IDX_W];
            addr_in  = q_ff.range_start[ADDR_W+BIT_IDX_W-1:BIT_IDX_W];
            count_in = '0;
            rem_in   = q_ff.kth;
            hit_in   = 1'b0;
            pos_in   = '0;
         end
         OP_SCAN: begin
            count_in = count_ff + LEN_W'(pc);
            rem_in   = rem_ff - LEN_W'(pc);
            addr_in  = addr_ff + ADDR_W'(1);
            if (scan_hit) begin
               hit_in = 1'b1;
               pos_in = base + LEN_W'(sel_idx);
            end
         end
         OP_FINISH: begin
            if (q_ff.action == ACT_RANK) begin
               res_in = '{answer: ANS_W'(count_ff), found: 1'b1};
            end else if (hit_ff) begin
               res_in = '{answer: ANS_W'(pos_ff), found: 1'b1};
            end else begin
               res_in = '{answer: '1, found: 1'b0};
            end
         end
         OP_RESULT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff     <= q_in;
      endc_ff  <= endc_in;
      last_ff  <= last_in;
      addr_ff  <= addr_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      pos_ff   <= pos_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_len_aligned: assert property (@(posedge clock) disable iff (reset)
      len_ff[BIT_IDX_W-1:0] == '0 && {1'b0, len_ff} <= (LEN_W+1)'(MAX_BITS))
      else $error("length not whole bytes or beyond capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_SCAN |-> addr_ff <= last_ff)
      else $error("scan past last byte of range");

   // checked while the hit still belongs to the word being finished
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_FINISH && hit_ff) |->
         (pos_ff < endc_ff && pos_ff >= q_ff.range_start))
      else $error("select position outside range");

endmodule

/* verif/bitvector_rank_select_test.sv */
// self-checking testbench for the bit vector rank/select block
`timescale 1ns / 100ps

module bitvector_rank_select_test;
   import bvrs_pkg::*;

   localparam int WORD_TARGET = 1170;   // input words to send
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int TAIL_CYCLES = 600;    // drain time after the last result

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   bitvector_rank_select u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // words waiting to be sent, and answers waiting to come back
   req_word_type pending_words[$];
   rsp_word_type expected_answers[$];

   // predictor copy of the vector, updated on each accepted word
   logic [7:0] vec_bytes [STORE_BYTES];
   int         vec_len = 0;

   // length as the stimulus generator sees it, to aim ranges at loaded bits
   int gen_len   = 0;
   int gen_count = 0;

   int words_sent  = 0;
   int mismatches  = 0;

   // sender burst/gap state
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall state
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   rx_mode   = 0;
   int   mode_left = 0;
   logic toggle    = 1'b0;

   // predicted answer for one word; updates the vector copy as the block does
   function automatic rsp_word_type compute_answer(req_word_type w);
      rsp_word_type r;
      int   lo, hi, count;
      logic hit;
      r.answer = '0;
      r.found  = 1'b1;
      lo       = int'(w.range_start);
      // end of range is clamped to the loaded length
      hi       = (int'(w.range_end) > vec_len) ? vec_len : int'(w.range_end);
      count    = 0;
      hit      = 1'b0;
      case (w.action)
         ACT_CLEAR: begin
            vec_len = 0;
         end
         ACT_APPEND: begin
            // a byte that would overflow the store is dropped
            if (vec_len + BITS_PER_BYTE <= MAX_BITS) begin
               vec_bytes[vec_len / BITS_PER_BYTE] = w.data_byte;
               vec_len += BITS_PER_BYTE;
            end else begin
               r.found = 1'b0;
            end
         end
         ACT_RANK: begin
            for (int i = lo; i < hi; i++)
               if (vec_bytes[i / BITS_PER_BYTE][i % BITS_PER_BYTE] == w.bit_value)
                  count++;
            r.answer = ANS_W'(count);
         end
         default: begin
            // select: kth counts from one, so zero never hits
            if (w.kth != 0) begin
               for (int i = lo; i < hi; i++) begin
                  if (!hit && vec_bytes[i / BITS_PER_BYTE][i % BITS_PER_BYTE] == w.bit_value) begin
                     count++;
                     if (count == int'(w.kth)) begin
                        hit      = 1'b1;
                        r.answer = ANS_W'(i);
                     end
                  end
               end
            end
            if (!hit) begin
               r.answer = -1;
               r.found  = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   task automatic push_word(action_type act, int data, int bv, int lo, int hi, int k);
      req_word_type w;
      w.action      = act;
      w.data_byte   = 8'(data);
      w.bit_value   = 1'(bv);
      w.range_start = LEN_W'(lo);
      w.range_end   = LEN_W'(hi);
      w.kth         = LEN_W'(k);
      if (act == ACT_CLEAR)
         gen_len = 0;
      else if (act == ACT_APPEND && gen_len + BITS_PER_BYTE <= MAX_BITS)
         gen_len += BITS_PER_BYTE;
      pending_words.push_back(w);
      gen_count++;
   endtask

   // rank or select with a range aimed mostly at the loaded bits
   task automatic random_query();
      int lo, hi, k, span;
      lo = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, gen_len);
      case ($urandom_range(0, 7))
         0:       hi = $urandom_range(0, 8191);
         1:       hi = gen_len;
         2:       hi = MAX_BITS;
         default: hi = $urandom_range(lo, gen_len);
      endcase
      span = (hi > lo) ? hi - lo : 0;
      k    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, span + 1);
      push_word($urandom_range(0, 1) ? ACT_SELECT : ACT_RANK, $urandom_range(0, 255),
                $urandom_range(0, 1), lo, hi, k);
   endtask

   // stimulus, end of run and verdict
   initial begin : main_flow
      int   n_bytes;
      int   n_queries;
      logic filled;

      // directed: empty vector first
      push_word(ACT_RANK,   8'h00, 1, 0, MAX_BITS, 0);
      push_word(ACT_SELECT, 8'hff, 0, 0, MAX_BITS, 1);
      // four bytes: all zeros, all ones, two mixed
      push_word(ACT_APPEND, 8'h00, 0, 0, 0, 0);
      push_word(ACT_APPEND, 8'hff, 1, 8191, 8191, 8191);
      push_word(ACT_APPEND, 8'ha5, 0, 0, 0, 0);
      push_word(ACT_APPEND, 8'h5a, 1, 4096, 4096, 4096);
      // end past the length gets clamped
      push_word(ACT_RANK,   8'h00, 1, 0, 8191, 8191);
      push_word(ACT_RANK,   8'hff, 0, 0, 32, 0);
      push_word(ACT_RANK,   8'h00, 1, 3, 29, 0);
      // inverted range and start far past the end
      push_word(ACT_RANK,   8'h00, 1, 20, 10, 0);
      push_word(ACT_RANK,   8'h00, 0, 8191, 8191, 0);
      // zeroth bit does not exist
      push_word(ACT_SELECT, 8'h00, 1, 0, 32, 0);
      push_word(ACT_SELECT, 8'h00, 1, 0, 32, 1);
      // last matching zero sits on the very last loaded bit
      push_word(ACT_SELECT, 8'h00, 0, 0, 32, 16);
      push_word(ACT_SELECT, 8'h00, 1, 0, 32, 17);
      push_word(ACT_SELECT, 8'h00, 1, 0, 8191, 8191);
      push_word(ACT_SELECT, 8'h00, 1, 9, 12, 2);
      push_word(ACT_SELECT, 8'h00, 0, 20, 10, 1);
      // clear keeps the bytes but nothing is readable
      push_word(ACT_CLEAR,  8'h00, 0, 0, 0, 0);
      push_word(ACT_RANK,   8'h00, 0, 0, MAX_BITS, 0);
      push_word(ACT_SELECT, 8'h00, 0, 0, MAX_BITS, 1);
      push_word(ACT_APPEND, 8'h81, 0, 0, 0, 0);
      push_word(ACT_RANK,   8'h00, 1, 0, 8, 0);
      push_word(ACT_SELECT, 8'h00, 1, 0, 8, 2);

      // random sessions: load a short vector, then query it
      filled = 1'b0;
      while (gen_count < WORD_TARGET) begin
         if (!filled && gen_count >= 300) begin
            // one full vector, a few appends past full, then wide queries
            filled = 1'b1;
            push_word(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1),
                      $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191));
            for (int b = 0; b < STORE_BYTES + 3; b++)
               push_word(ACT_APPEND, $urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191));
            for (int q = 0; q < 30; q++)
               random_query();
         end else if ($urandom_range(0, 9) == 0) begin
            // noise: any action, any field
            repeat ($urandom_range(1, 3))
               push_word(action_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                         $urandom_range(0, 1), $urandom_range(0, 8191),
                         $urandom_range(0, 8191), $urandom_range(0, 8191));
         end else begin
            if ($urandom_range(0, 4) != 0)
               push_word(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191));
            case ($urandom_range(0, 9))
               0:       n_bytes = 0;
               1, 2:    n_bytes = $urandom_range(9, 64);
               default: n_bytes = $urandom_range(1, 8);
            endcase
            for (int b = 0; b < n_bytes; b++)
               push_word(ACT_APPEND, $urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, 8191), $urandom_range(0, 8191),
                         $urandom_range(0, 8191));
            n_queries = $urandom_range(2, 10);
            for (int q = 0; q < n_queries; q++)
               random_query();
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // everything sent and every answer back
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_answers.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);

      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #25_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // sender: bursts of words with random gaps, valid held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            // word taken: predict its answer now, in acceptance order
            expected_answers.push_back(compute_answer(req_data));
            words_sent <= words_sent + 1;
         end
         // only move on when the channel is free or the word just went
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  case ($urandom_range(0, 5))
                     0, 1:    gap_left = 0;
                     2:       gap_left = $urandom_range(20, 40);
                     default: gap_left = $urandom_range(1, 12);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each answer word, stalls on its own pattern
   always @(posedge clock) begin : rsp_side
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result word with nothing pending: answer %0d found %0b",
                           rsp_data.answer, rsp_data.found);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_data.answer !== want.answer || rsp_data.found !== want.found) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: answer exp %0d got %0d, found exp %0b got %0b",
                              want.answer, rsp_data.answer, want.found, rsp_data.found);
               end
            end
         end

         if (hold_left > 0) begin
            // long hold-off: the block fills and must stop taking words
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_sent >= 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left <= 0) begin
               rx_mode   = $urandom_range(0, 3);
               mode_left = $urandom_range(32, 96);
            end
            mode_left--;
            toggle = ~toggle;
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= toggle;
            endcase
         end
      end
   end

endmodule
